// File: rtl/ljpf_pkg.sv
package ljpf_pkg;

    // Field widths fixed by the interface
    localparam int COORD_W   = 32;
    localparam int OUT_W     = 48;
    localparam int SQ_W      = 64;
    localparam int C6_W      = 48;
    localparam int CFG_IDX_W = 2;

    // Reset value of the box edge in whole units
    localparam int BOX_RESET_UNITS = 10;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Pipeline depths
    localparam int DIV_STAGES = SQ_W;
    localparam int MUL_STAGES = 2;
    localparam int LATENCY    = 9 + 4 * DIV_STAGES + 3 * MUL_STAGES;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_LENGTH  = 2'd0,
        REG_SIGMA_SIXTH = 2'd1,
        REG_WELL_DEPTH  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] first_z;
        logic [COORD_W-1:0] second_x;
        logic [COORD_W-1:0] second_y;
        logic [COORD_W-1:0] second_z;
    } ljpf_pair_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] pair_energy;
        logic signed [OUT_W-1:0] force_x;
        logic signed [OUT_W-1:0] force_y;
        logic signed [OUT_W-1:0] force_z;
        logic                    range_flag;
    } ljpf_result_t;

    // Data that rides alongside an item through the pipeline
    typedef struct packed {
        logic [2:0]               dneg;
        logic [2:0][COORD_W-1:0]  mag;
        logic [SQ_W-1:0]          dist_sq;
        logic                     dist_zero;
        logic                     c6_ovf;
        logic                     t_ovf;
        logic                     eneg;
        logic                     hneg;
        logic [OUT_W-1:0]         energy;
        logic                     energy_sat;
    } ljpf_side_t;

endpackage

// File: rtl/ljpf_mul.sv
module ljpf_mul #(
    parameter int A_W    = 48,
    parameter int B_W    = 48,
    parameter int SIDE_W = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    input  logic [SIDE_W-1:0]  side_in,
    output logic               out_valid,
    output logic [A_W+B_W-1:0] product,
    output logic [SIDE_W-1:0]  side_out
);

    localparam int CH    = 32;
    localparam int NA    = (A_W + CH - 1) / CH;
    localparam int NB    = (B_W + CH - 1) / CH;
    localparam int PW    = A_W + B_W;
    localparam int SUM_W = (NA + NB) * CH;

    logic [NA*CH-1:0]  a_pad;
    logic [NB*CH-1:0]  b_pad;
    logic [2*CH-1:0]   pp_reg [NA][NB];
    logic              v1_reg;
    logic              v2_reg;
    logic [SIDE_W-1:0] side1_reg;
    logic [SIDE_W-1:0] side2_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [PW-1:0]     prod_reg;

    assign a_pad = (NA*CH)'(a);
    assign b_pad = (NB*CH)'(b);

    // Partial products, one 32x32 multiplier each
    for (genvar i = 0; i < NA; i++) begin : g_row
        for (genvar j = 0; j < NB; j++) begin : g_col
            always_ff @(posedge clk)
            begin
                pp_reg[i][j] <= a_pad[i*CH +: CH] * b_pad[j*CH +: CH];
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                sum_next = sum_next + (SUM_W'(pp_reg[i][j]) << (CH * (i + j)));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg <= side_in;
        side2_reg <= side1_reg;
        prod_reg  <= sum_next[PW-1:0];
    end

    assign out_valid = v2_reg;
    assign product   = prod_reg;
    assign side_out  = side2_reg;

endmodule

// File: rtl/ljpf_div.sv
module ljpf_div #(
    parameter int SIDE_W = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [ljpf_pkg::SQ_W-1:0] rem_in,
    input  logic [ljpf_pkg::SQ_W-1:0] low_in,
    input  logic [ljpf_pkg::SQ_W-1:0] divisor,
    input  logic [SIDE_W-1:0]        side_in,
    output logic                     out_valid,
    output logic [ljpf_pkg::SQ_W-1:0] quotient,
    output logic [SIDE_W-1:0]        side_out
);

    import ljpf_pkg::*;

    localparam int W    = SQ_W;
    localparam int LAST = DIV_STAGES - 1;

    logic              vld_reg  [DIV_STAGES];
    logic [W-1:0]      rem_reg  [DIV_STAGES];
    logic [W-1:0]      low_reg  [DIV_STAGES];
    logic [W-1:0]      quo_reg  [DIV_STAGES];
    logic [W-1:0]      dsr_reg  [DIV_STAGES];
    logic [SIDE_W-1:0] side_reg [DIV_STAGES];

    // Restoring division, one quotient bit per stage; rem_in must be below divisor
    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_step
        logic              vld_prev;
        logic [W-1:0]      rem_prev;
        logic [W-1:0]      low_prev;
        logic [W-1:0]      quo_prev;
        logic [W-1:0]      dsr_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [W:0]        trial;
        logic [W:0]        diff;
        logic              take;

        if (i == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign rem_prev  = rem_in;
            assign low_prev  = low_in;
            assign quo_prev  = '0;
            assign dsr_prev  = divisor;
            assign side_prev = side_in;
        end
        else begin : g_next
            assign vld_prev  = vld_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign low_prev  = low_reg[i-1];
            assign quo_prev  = quo_reg[i-1];
            assign dsr_prev  = dsr_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        assign trial = {rem_prev, low_prev[W-1]};
        assign diff  = trial - {1'b0, dsr_prev};
        assign take  = !diff[W];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= take ? diff[W-1:0] : trial[W-1:0];
            low_reg[i]  <= {low_prev[W-2:0], 1'b0};
            quo_reg[i]  <= {quo_prev[W-2:0], take};
            dsr_reg[i]  <= dsr_prev;
            side_reg[i] <= side_prev;
        end
    end

    assign out_valid = vld_reg[LAST];
    assign quotient  = quo_reg[LAST];
    assign side_out  = side_reg[LAST];

endmodule

// File: rtl/lennard_jones_pair_force.sv
// Pipeline: a pair accepted at one clock edge gives its result, with done high,
// after nine single stages, four 64-stage dividers and three multipliers.
// Throughput: one pair per cycle; busy never rises, so start may be held high.
// The receiver cannot stall, so done is a one-cycle strobe and nothing is held back.
// Reset (rst_n low, asynchronous) clears every valid bit and sets box_length to 10.0,
// sigma_sixth and well_depth to 1.0; configuration writes are taken in any cycle.
module lennard_jones_pair_force #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  ljpf_pkg::ljpf_pair_t             pair,
    output logic                             done,
    output ljpf_pkg::ljpf_result_t           result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ljpf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ljpf_pkg::COORD_W-1:0]     cfg_data
);

    import ljpf_pkg::*;

    localparam int SIDE_W = $bits(ljpf_side_t);
    localparam int P1_W   = 2 * C6_W;              // c6 times a c6-sized term
    localparam int P2_W   = P1_W + COORD_W;        // then times the well depth
    localparam int FP_W   = SQ_W + COORD_W;        // prefactor times a distance
    localparam int SC_W   = FP_W + 6;              // after the factor of 48

    localparam logic [C6_W-1:0] C6_ONE  = C6_W'(1) << FRACTION_BITS;
    localparam logic [C6_W-1:0] C6_HALF = C6_W'(1) << (FRACTION_BITS - 1);
    localparam logic [C6_W-1:0] C6_CAP  = {C6_W{1'b1}};

    localparam logic [COORD_W-1:0] BOX_RESET = COORD_W'(BOX_RESET_UNITS) << FRACTION_BITS;
    localparam logic [COORD_W-1:0] ONE_RESET = COORD_W'(1) << FRACTION_BITS;

    // Operands of one restoring division
    typedef struct packed {
        logic            ovf;
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] low;
    } div_in_t;

    // Fold a coordinate difference to the minimum image; return {negative, magnitude}
    function automatic logic [COORD_W:0] fold_coord(
        input logic [COORD_W-1:0] p,
        input logic [COORD_W-1:0] q,
        input logic [COORD_W-1:0] box
    );
        logic signed [COORD_W+2:0] d;
        logic signed [COORD_W+2:0] twice;
        logic signed [COORD_W+2:0] span;
        d     = $signed({3'b000, p}) - $signed({3'b000, q});
        twice = d <<< 1;
        span  = $signed({3'b000, box});
        if (twice > span)
        begin
            d = d - span;
        end
        else if (twice <= -span)
        begin
            d = d + span;
        end
        return {d[COORD_W+2], d[COORD_W+2] ? COORD_W'(-d) : COORD_W'(d)};
    endfunction

    // Split u * 2^(2F) into a remainder and low word for division by s;
    // the quotient overflows 64 bits exactly when the high word reaches s
    function automatic div_in_t div_prep(input logic [SQ_W-1:0] u, input logic [SQ_W-1:0] s);
        logic [SQ_W-1:0] hi;
        div_in_t         r;
        hi    = u >> (SQ_W - 2 * FRACTION_BITS);
        r.ovf = (hi >= s);
        r.rem = r.ovf ? '0 : hi;
        r.low = u << (2 * FRACTION_BITS);
        return r;
    endfunction

    // Signed saturation of a magnitude; return {saturated, value}
    function automatic logic [OUT_W:0] sat_out(input logic neg, input logic [P2_W-1:0] m);
        if (!neg)
        begin
            if (m > P2_W'(OUT_MAX))
            begin
                return {1'b1, OUT_MAX};
            end
            return {1'b0, m[OUT_W-1:0]};
        end
        if (m > P2_W'(OUT_MAX) + P2_W'(1))
        begin
            return {1'b1, OUT_MIN};
        end
        return {1'b0, OUT_W'(-m[OUT_W-1:0])};
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers; the port never pushes back
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] box_length_reg;
    logic [COORD_W-1:0] sigma_sixth_reg;
    logic [COORD_W-1:0] well_depth_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_length_reg  <= BOX_RESET;
            sigma_sixth_reg <= ONE_RESET;
            well_depth_reg  <= ONE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BOX_LENGTH:  box_length_reg  <= cfg_data;
                REG_SIGMA_SIXTH: sigma_sixth_reg <= cfg_data;
                REG_WELL_DEPTH:  well_depth_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Every stage advances every cycle, so a new pair is always welcome
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage A: differences and minimum-image fold
    // ------------------------------------------------------------------
    logic [2:0][COORD_W-1:0] pos_a;
    logic [2:0][COORD_W-1:0] pos_b;
    logic                    a_vld_reg;
    ljpf_side_t              a_side_next;
    ljpf_side_t              a_side_reg;

    assign pos_a = {pair.first_z, pair.first_y, pair.first_x};
    assign pos_b = {pair.second_z, pair.second_y, pair.second_x};

    always_comb
    begin
        a_side_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            {a_side_next.dneg[k], a_side_next.mag[k]} =
                fold_coord(pos_a[k], pos_b[k], box_length_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage B: squares, one multiplier per axis
    // ------------------------------------------------------------------
    logic                  b_vld_reg;
    ljpf_side_t            b_side_reg;
    logic [2:0][SQ_W-1:0]  b_sq_reg;

    // ------------------------------------------------------------------
    // Stage C: saturating sum of squares
    // ------------------------------------------------------------------
    logic [SQ_W+1:0] sum3;
    logic            c_vld_reg;
    ljpf_side_t      c_side_next;
    ljpf_side_t      c_side_reg;

    assign sum3 = {2'b00, b_sq_reg[0]} + {2'b00, b_sq_reg[1]} + {2'b00, b_sq_reg[2]};

    always_comb
    begin
        c_side_next           = b_side_reg;
        c_side_next.dist_sq   = (sum3[SQ_W+1:SQ_W] != 2'b00) ? {SQ_W{1'b1}} : sum3[SQ_W-1:0];
        c_side_next.dist_zero = (sum3 == '0);
        c_side_next.c6_ovf    = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start && !busy;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_side_reg <= a_side_next;
        b_side_reg <= a_side_reg;
        for (int k = 0; k < 3; k++)
        begin
            b_sq_reg[k] <= a_side_reg.mag[k] * a_side_reg.mag[k];
        end
        c_side_reg <= c_side_next;
    end

    // ------------------------------------------------------------------
    // c6 = sigma^6 / r2^3: three chained divisions, each behind a prep stage
    // ------------------------------------------------------------------
    logic             p_vld_reg  [3];
    ljpf_side_t       p_side_reg [3];
    logic [SQ_W-1:0]  p_rem_reg  [3];
    logic [SQ_W-1:0]  p_low_reg  [3];
    logic             c6_vld     [3];
    logic [SQ_W-1:0]  c6_quo     [3];
    ljpf_side_t       c6_side    [3];

    for (genvar k = 0; k < 3; k++) begin : g_c6
        logic            vld_in;
        logic [SQ_W-1:0] u;
        ljpf_side_t      side_in;
        ljpf_side_t      side_next;
        div_in_t         prep;

        if (k == 0) begin : g_src_sigma
            assign vld_in  = c_vld_reg;
            assign u       = SQ_W'(sigma_sixth_reg);
            assign side_in = c_side_reg;
        end
        else begin : g_src_prev
            assign vld_in  = c6_vld[k-1];
            assign u       = c6_quo[k-1];
            assign side_in = c6_side[k-1];
        end

        assign prep = div_prep(u, side_in.dist_sq);

        always_comb
        begin
            side_next        = side_in;
            side_next.c6_ovf = side_in.c6_ovf | prep.ovf;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                p_vld_reg[k] <= 1'b0;
            end
            else
            begin
                p_vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            p_side_reg[k] <= side_next;
            p_rem_reg[k]  <= prep.rem;
            p_low_reg[k]  <= prep.low;
        end

        ljpf_div #(
            .SIDE_W (SIDE_W)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (p_vld_reg[k]),
            .rem_in    (p_rem_reg[k]),
            .low_in    (p_low_reg[k]),
            .divisor   (p_side_reg[k].dist_sq),
            .side_in   (p_side_reg[k]),
            .out_valid (c6_vld[k]),
            .quotient  (c6_quo[k]),
            .side_out  (c6_side[k])
        );
    end

    // ------------------------------------------------------------------
    // Stage E: c6 cap check, |c6 - 1| and |c6 - 1/2| with their signs
    // ------------------------------------------------------------------
    logic [C6_W-1:0] c6_val;
    ljpf_side_t      e_side_next;
    logic            e_vld_reg;
    ljpf_side_t      e_side_reg;
    logic [C6_W-1:0] e_c6_reg;
    logic [C6_W-1:0] e_cm_reg;
    logic [C6_W-1:0] e_hm_reg;

    assign c6_val = c6_quo[2][C6_W-1:0];

    always_comb
    begin
        e_side_next        = c6_side[2];
        e_side_next.c6_ovf = c6_side[2].c6_ovf | (c6_quo[2] > SQ_W'(C6_CAP));
        e_side_next.eneg   = (c6_val < C6_ONE);
        e_side_next.hneg   = (c6_val < C6_HALF);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
        end
        else
        begin
            e_vld_reg <= c6_vld[2];
        end
    end

    always_ff @(posedge clk)
    begin
        e_side_reg <= e_side_next;
        e_c6_reg   <= c6_val;
        e_cm_reg   <= e_side_next.eneg ? (C6_ONE - c6_val) : (c6_val - C6_ONE);
        e_hm_reg   <= e_side_next.hneg ? (C6_HALF - c6_val) : (c6_val - C6_HALF);
    end

    // ------------------------------------------------------------------
    // Products: c6*|c6-1|*eps for the energy, c6*|c6-1/2|*eps for the force
    // ------------------------------------------------------------------
    logic            m1_vld;
    logic [P1_W-1:0] m1e_prod;
    logic [P1_W-1:0] m1f_prod;
    ljpf_side_t      m1_side;
    logic            m2_vld;
    logic [P2_W-1:0] m2e_prod;
    logic [P2_W-1:0] m2f_prod;
    ljpf_side_t      m2_side;

    ljpf_mul #(
        .A_W    (C6_W),
        .B_W    (C6_W),
        .SIDE_W (SIDE_W)
    ) u_mul_e1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (e_vld_reg),
        .a         (e_c6_reg),
        .b         (e_cm_reg),
        .side_in   (e_side_reg),
        .out_valid (m1_vld),
        .product   (m1e_prod),
        .side_out  (m1_side)
    );

    ljpf_mul #(
        .A_W    (C6_W),
        .B_W    (C6_W),
        .SIDE_W (1)
    ) u_mul_f1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (e_vld_reg),
        .a         (e_c6_reg),
        .b         (e_hm_reg),
        .side_in   (1'b0),
        .out_valid (),
        .product   (m1f_prod),
        .side_out  ()
    );

    ljpf_mul #(
        .A_W    (P1_W),
        .B_W    (COORD_W),
        .SIDE_W (SIDE_W)
    ) u_mul_e2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m1_vld),
        .a         (m1e_prod),
        .b         (well_depth_reg),
        .side_in   (m1_side),
        .out_valid (m2_vld),
        .product   (m2e_prod),
        .side_out  (m2_side)
    );

    ljpf_mul #(
        .A_W    (P1_W),
        .B_W    (COORD_W),
        .SIDE_W (1)
    ) u_mul_f2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m1_vld),
        .a         (m1f_prod),
        .b         (well_depth_reg),
        .side_in   (1'b0),
        .out_valid (),
        .product   (m2f_prod),
        .side_out  ()
    );

    // ------------------------------------------------------------------
    // Stage F: energy scaling and saturation; set up the force prefactor division
    // ------------------------------------------------------------------
    logic [OUT_W:0]  e_sat;
    logic [SQ_W-1:0] t_hi;
    logic            t_ovf;
    ljpf_side_t      f_side_next;
    logic            f_vld_reg;
    ljpf_side_t      f_side_reg;
    logic [SQ_W-1:0] f_rem_reg;
    logic [SQ_W-1:0] f_low_reg;

    assign e_sat = sat_out(m2_side.eneg, m2e_prod >> (2 * FRACTION_BITS - 2));
    assign t_hi  = m2f_prod[P2_W-1 -: SQ_W];
    assign t_ovf = (t_hi >= m2_side.dist_sq);

    always_comb
    begin
        f_side_next            = m2_side;
        f_side_next.energy     = e_sat[OUT_W-1:0];
        f_side_next.energy_sat = e_sat[OUT_W];
        f_side_next.t_ovf      = t_ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else
        begin
            f_vld_reg <= m2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        f_side_reg <= f_side_next;
        f_rem_reg  <= t_ovf ? '0 : t_hi;
        f_low_reg  <= m2f_prod[SQ_W-1:0];
    end

    logic            t_vld;
    logic [SQ_W-1:0] t_quo;
    ljpf_side_t      t_side;

    ljpf_div #(
        .SIDE_W (SIDE_W)
    ) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_vld_reg),
        .rem_in    (f_rem_reg),
        .low_in    (f_low_reg),
        .divisor   (f_side_reg.dist_sq),
        .side_in   (f_side_reg),
        .out_valid (t_vld),
        .quotient  (t_quo),
        .side_out  (t_side)
    );

    // ------------------------------------------------------------------
    // Force lanes: t * |d| per axis, then the factor 48 and saturation
    // ------------------------------------------------------------------
    logic                 g_vld      [3];
    ljpf_side_t           g_side     [3];
    logic [FP_W-1:0]      lane_prod  [3];
    logic [OUT_W:0]       lane_sat   [3];

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic [SC_W-1:0] scaled;

        ljpf_mul #(
            .A_W    (SQ_W),
            .B_W    (COORD_W),
            .SIDE_W (SIDE_W)
        ) u_mul_t (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (t_vld),
            .a         (t_quo),
            .b         (t_side.mag[k]),
            .side_in   (t_side),
            .out_valid (g_vld[k]),
            .product   (lane_prod[k]),
            .side_out  (g_side[k])
        );

        assign scaled      = (SC_W'(lane_prod[k]) << 5) + (SC_W'(lane_prod[k]) << 4);
        assign lane_sat[k] = sat_out(g_side[k].hneg ^ g_side[k].dneg[k],
                                     P2_W'(scaled >> FRACTION_BITS));
    end

    // ------------------------------------------------------------------
    // Stage G: special cases and the result register
    // ------------------------------------------------------------------
    ljpf_side_t               g_info;
    logic [2:0][OUT_W-1:0]    frc_next;
    ljpf_result_t             res_next;
    logic                     done_reg;
    ljpf_result_t             result_reg;

    assign g_info = g_side[0];

    always_comb
    begin
        res_next = '0;
        frc_next = '0;
        priority if (g_info.dist_zero)
        begin
            res_next.pair_energy = OUT_MAX;
            res_next.range_flag  = 1'b1;
        end
        else if (well_depth_reg == '0)
        begin
            res_next.range_flag = 1'b0;
        end
        else if (g_info.c6_ovf)
        begin
            // Too close: pin the energy and push each force hard along d
            res_next.pair_energy = OUT_MAX;
            res_next.range_flag  = 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                if (g_info.mag[k] != '0)
                begin
                    frc_next[k] = g_info.dneg[k] ? OUT_MIN : OUT_MAX;
                end
            end
        end
        else
        begin
            res_next.pair_energy = g_info.energy;
            res_next.range_flag  = g_info.energy_sat;
            for (int k = 0; k < 3; k++)
            begin
                if (g_info.mag[k] != '0)
                begin
                    if (g_info.t_ovf)
                    begin
                        frc_next[k] = (g_info.hneg ^ g_info.dneg[k]) ? OUT_MIN : OUT_MAX;
                        res_next.range_flag = 1'b1;
                    end
                    else
                    begin
                        frc_next[k] = lane_sat[k][OUT_W-1:0];
                        res_next.range_flag = res_next.range_flag | lane_sat[k][OUT_W];
                    end
                end
            end
        end
        res_next.force_x = frc_next[0];
        res_next.force_y = frc_next[1];
        res_next.force_z = frc_next[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= g_vld[0];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/ljpf_check.sv
module ljpf_check (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   done,
    input ljpf_pkg::ljpf_pair_t   pair,
    input ljpf_pkg::ljpf_result_t result
);

    import ljpf_pkg::*;

    // Every accepted pair comes out after the fixed latency
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("accepted pair gave no result at the expected cycle");

    // No result appears without a pair accepted the latency before
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching accepted pair");

    // Coincident particles: pinned energy, no force, flag raised
    a_coincident: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(pair.first_x == pair.second_x && pair.first_y == pair.second_y
                      && pair.first_z == pair.second_z, LATENCY)
        |-> result.range_flag && result.pair_energy == OUT_MAX && result.force_x == '0
            && result.force_y == '0 && result.force_z == '0)
        else $error("zero-distance pair gave a wrong result");

endmodule

bind lennard_jones_pair_force ljpf_check u_ljpf_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .pair   (pair),
    .result (result)
);
